@@ src/brb_pkg.sv @@
// Package for the byte ring buffer: opcode and status codes, default sizes,
// and the occupancy struct passed between the level calculator and the top.
// Depends on nothing.
`default_nettype none

package brb_pkg;

    localparam int CAPACITY_DEF  = 4096;
    localparam int MAX_CHUNK_DEF = 64;
    localparam int FIELD_W       = 12;
    localparam int CFG_W         = 13;
    localparam int LVL_W         = 17;

    typedef logic [2:0] opcode_t;
    localparam opcode_t OP_ENQ        = 3'd0;
    localparam opcode_t OP_DEQ        = 3'd1;
    localparam opcode_t OP_PEEK       = 3'd2;
    localparam opcode_t OP_MOVE_REAR  = 3'd3;
    localparam opcode_t OP_MOVE_FRONT = 3'd4;
    localparam opcode_t OP_CLEAR      = 3'd5;
    localparam opcode_t OP_QUERY      = 3'd6;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_NO_ROOM = 2'd1;
    localparam status_t ST_NO_DATA = 2'd2;
    localparam status_t ST_BAD_CNT = 2'd3;

    typedef struct packed {
        logic [LVL_W-1:0] used_cnt;
        logic [LVL_W-1:0] free_cnt;
        logic [LVL_W-1:0] denq_cnt;
        logic [LVL_W-1:0] ddeq_cnt;
    } level_t;

endpackage

`default_nettype wire

@@ src/brb_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds when no read is issued. Uses no package.
`default_nettype none

module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/brb_level.sv @@
// Occupancy calculator: used, free and the two no-wrap sizes from the
// pointers and the configured size. Depends on brb_pkg (level_t).
`default_nettype none

module brb_level #(
    parameter int CAPACITY = brb_pkg::CAPACITY_DEF
) (
    input  wire logic [$clog2(CAPACITY+1)-1:0] size,
    input  wire logic [$clog2(CAPACITY)-1:0]   front,
    input  wire logic [$clog2(CAPACITY)-1:0]   rear,
    output brb_pkg::level_t                    lvl
);
    import brb_pkg::*;

    localparam int SIZE_W = $clog2(CAPACITY + 1);

    logic [SIZE_W-1:0] f_ext;
    logic [SIZE_W-1:0] r_ext;
    logic [SIZE_W-1:0] used;
    logic [SIZE_W-1:0] free;
    logic [SIZE_W-1:0] denq;
    logic [SIZE_W-1:0] ddeq;

    always_comb
    begin
        f_ext = SIZE_W'(front);
        r_ext = SIZE_W'(rear);
        if (f_ext > r_ext)
        begin
            used = size - f_ext + r_ext;
            ddeq = size - f_ext;
        end
        else
        begin
            used = r_ext - f_ext;
            ddeq = r_ext - f_ext;
        end
        free = size - used - SIZE_W'(1);
        if (r_ext >= f_ext)
        begin
            denq = (f_ext == '0) ? (size - r_ext - SIZE_W'(1)) : (size - r_ext);
        end
        else
        begin
            denq = free;
        end
        lvl.used_cnt = LVL_W'(used);
        lvl.free_cnt = LVL_W'(free);
        lvl.denq_cnt = LVL_W'(denq);
        lvl.ddeq_cnt = LVL_W'(ddeq);
    end

endmodule

`default_nettype wire

@@ src/byte_ring_buffer.sv @@
// Byte ring buffer top level: control sequencer, pointer and chunk state.
// Depends on brb_pkg, brb_ram (byte store) and brb_level (occupancy).
//
// Usage:
//   Input channel (in_valid/in_stall) carries one item: opcode, chunk_first,
//   byte_count, data_byte. Output channel (out_valid/out_stall) carries the
//   results: status, read_byte, last and the four occupancy counts, taken
//   after the item's update. Each item yields one result, except a good
//   dequeue or peek, which yields byte_count results, the final one marked
//   by last.
//   Config channel (cfg_valid/cfg_ready) writes buffer_size, saturated to
//   [2, CAPACITY]; it clears both pointers and any chunk in progress.
//   Timing: an item is accepted in the idle state and its state update is
//   done at that edge. A single-result item is then reported from S_REPORT.
//   A dequeue/peek of N bytes streams one byte per cycle through the
//   store's registered read port while the output flows.
//   The output register holds a finished result while the next item is
//   accepted. When out_stall is high, the current result holds and the
//   byte stream pauses; in_stall stays high until the item's last result
//   is loaded into the output register.
//   Reset: pointers, chunk state and size (CAPACITY) reset at once; the
//   byte store is not cleared and the block is ready on reset release.
`default_nettype none

module byte_ring_buffer #(
    parameter int CAPACITY  = brb_pkg::CAPACITY_DEF,
    parameter int MAX_CHUNK = brb_pkg::MAX_CHUNK_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [brb_pkg::CFG_W-1:0]     buffer_size,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire brb_pkg::opcode_t              opcode,
    input  wire logic                          chunk_first,
    input  wire logic [brb_pkg::FIELD_W-1:0]   byte_count,
    input  wire logic [7:0]                    data_byte,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output brb_pkg::status_t                   status,
    output logic [7:0]                         read_byte,
    output logic                               last,
    output logic [brb_pkg::FIELD_W-1:0]        used_bytes,
    output logic [brb_pkg::FIELD_W-1:0]        free_bytes,
    output logic [brb_pkg::FIELD_W-1:0]        direct_enqueue_bytes,
    output logic [brb_pkg::FIELD_W-1:0]        direct_dequeue_bytes
);
    import brb_pkg::*;

    localparam int PTR_W  = $clog2(CAPACITY);
    localparam int SIZE_W = $clog2(CAPACITY + 1);
    localparam int AW     = ((SIZE_W > FIELD_W) ? SIZE_W : FIELD_W) + 1;
    localparam int CW     = $clog2(MAX_CHUNK + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REPORT,
        S_READ
    } state_t;

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [PTR_W-1:0]  front_reg, front_next;
    logic [PTR_W-1:0]  rear_reg, rear_next;
    logic [CW-1:0]     clen_reg, clen_next;
    logic [CW-1:0]     coff_reg, coff_next;
    logic              crej_reg, crej_next;
    status_t           pend_st_reg, pend_st_next;
    logic [PTR_W-1:0]  base_reg, base_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     iss_reg, iss_next;
    logic [CW-1:0]     emit_reg, emit_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              out_valid_reg, out_valid_next;
    status_t           status_reg, status_next;
    logic [7:0]        read_byte_reg, read_byte_next;
    logic              last_reg, last_next;
    logic [FIELD_W-1:0] used_reg, used_next;
    logic [FIELD_W-1:0] free_reg, free_next;
    logic [FIELD_W-1:0] denq_reg, denq_next;
    logic [FIELD_W-1:0] ddeq_reg, ddeq_next;

    level_t            lvl;
    logic              ram_we;
    logic [PTR_W-1:0]  ram_waddr;
    logic              ram_re;
    logic [PTR_W-1:0]  ram_raddr;
    logic [7:0]        ram_rdata;

    logic              slot_free;
    logic              load;
    logic              issue;
    logic              is_last;
    logic [CW-1:0]     e_len;
    logic [CW-1:0]     e_off;
    logic              e_rej;
    logic [CW-1:0]     off_inc;

    function automatic logic [PTR_W-1:0] wrap_add(
        input logic [PTR_W-1:0]  p,
        input logic [AW-1:0]     n,
        input logic [SIZE_W-1:0] sz
    );
        logic [AW-1:0] s;
        begin
            s = AW'(p) + n;
            if (s >= AW'(sz))
            begin
                s = s - AW'(sz);
            end
            return s[PTR_W-1:0];
        end
    endfunction

    brb_ram #(
        .WIDTH (8),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (data_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    brb_level #(
        .CAPACITY (CAPACITY)
    ) u_level (
        .size  (size_reg),
        .front (front_reg),
        .rear  (rear_reg),
        .lvl   (lvl)
    );

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE) || cfg_valid;
    assign slot_free = !out_valid_reg || !out_stall;
    assign load      = (state_reg == S_READ) && rd_pend_reg && slot_free;
    assign issue     = (state_reg == S_READ) && (iss_reg != cnt_reg)
                       && (!rd_pend_reg || load);
    assign is_last   = (emit_reg == cnt_reg - CW'(1));

    always_comb
    begin
        state_next     = state_reg;
        size_next      = size_reg;
        front_next     = front_reg;
        rear_next      = rear_reg;
        clen_next      = clen_reg;
        coff_next      = coff_reg;
        crej_next      = crej_reg;
        pend_st_next   = pend_st_reg;
        base_next      = base_reg;
        cnt_next       = cnt_reg;
        iss_next       = iss_reg;
        emit_next      = emit_reg;
        rd_pend_next   = rd_pend_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        read_byte_next = read_byte_reg;
        last_next      = last_reg;
        used_next      = used_reg;
        free_next      = free_reg;
        denq_next      = denq_reg;
        ddeq_next      = ddeq_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = wrap_add(base_reg, AW'(iss_reg), size_reg);
        e_len          = clen_reg;
        e_off          = coff_reg;
        e_rej          = crej_reg;
        if (chunk_first)
        begin
            e_len = byte_count[CW-1:0];
            e_off = '0;
            e_rej = lvl.free_cnt < LVL_W'(byte_count);
        end
        off_inc   = e_off + CW'(1);
        ram_waddr = wrap_add(rear_reg, AW'(e_off), size_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    if (buffer_size < CFG_W'(2))
                    begin
                        size_next = SIZE_W'(2);
                    end
                    else if (32'(buffer_size) > CAPACITY)
                    begin
                        size_next = SIZE_W'(CAPACITY);
                    end
                    else
                    begin
                        size_next = SIZE_W'(buffer_size);
                    end
                    front_next = '0;
                    rear_next  = '0;
                    clen_next  = '0;
                    coff_next  = '0;
                    crej_next  = 1'b0;
                end
                else if (in_valid)
                begin
                    state_next   = S_REPORT;
                    pend_st_next = ST_OK;
                    clen_next    = '0;
                    coff_next    = '0;
                    crej_next    = 1'b0;
                    unique case (opcode) inside
                        OP_ENQ:
                        begin
                            if (chunk_first && (byte_count == '0
                                || 32'(byte_count) > MAX_CHUNK))
                            begin
                                pend_st_next = ST_BAD_CNT;
                            end
                            else if (!chunk_first
                                     && (clen_reg == '0 || coff_reg >= clen_reg))
                            begin
                                pend_st_next = ST_BAD_CNT;
                                clen_next    = clen_reg;
                                coff_next    = coff_reg;
                                crej_next    = crej_reg;
                            end
                            else
                            begin
                                pend_st_next = e_rej ? ST_NO_ROOM : ST_OK;
                                ram_we       = !e_rej;
                                if (off_inc >= e_len)
                                begin
                                    if (!e_rej)
                                    begin
                                        rear_next = wrap_add(rear_reg, AW'(e_len),
                                                             size_reg);
                                    end
                                end
                                else
                                begin
                                    clen_next = e_len;
                                    coff_next = off_inc;
                                    crej_next = e_rej;
                                end
                            end
                        end
                        OP_DEQ, OP_PEEK:
                        begin
                            if (byte_count == '0)
                            begin
                                pend_st_next = ST_OK;
                            end
                            else if (32'(byte_count) > MAX_CHUNK)
                            begin
                                pend_st_next = ST_BAD_CNT;
                            end
                            else if (lvl.used_cnt < LVL_W'(byte_count))
                            begin
                                pend_st_next = ST_NO_DATA;
                            end
                            else
                            begin
                                state_next   = S_READ;
                                base_next    = front_reg;
                                cnt_next     = byte_count[CW-1:0];
                                iss_next     = '0;
                                emit_next    = '0;
                                rd_pend_next = 1'b0;
                                if (opcode == OP_DEQ)
                                begin
                                    front_next = wrap_add(front_reg, AW'(byte_count),
                                                          size_reg);
                                end
                            end
                        end
                        OP_MOVE_REAR, OP_MOVE_FRONT:
                        begin
                            if (AW'(byte_count) >= AW'(size_reg))
                            begin
                                pend_st_next = ST_BAD_CNT;
                            end
                            else if (opcode == OP_MOVE_REAR)
                            begin
                                rear_next = wrap_add(rear_reg, AW'(byte_count), size_reg);
                            end
                            else
                            begin
                                front_next = wrap_add(front_reg, AW'(byte_count),
                                                      size_reg);
                            end
                        end
                        OP_CLEAR:
                        begin
                            front_next = '0;
                            rear_next  = '0;
                        end
                        default:
                        begin
                            pend_st_next = ST_OK;
                        end
                    endcase
                end
            end
            S_REPORT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = pend_st_reg;
                    read_byte_next = '0;
                    last_next      = 1'b1;
                    used_next      = lvl.used_cnt[FIELD_W-1:0];
                    free_next      = lvl.free_cnt[FIELD_W-1:0];
                    denq_next      = lvl.denq_cnt[FIELD_W-1:0];
                    ddeq_next      = lvl.ddeq_cnt[FIELD_W-1:0];
                    state_next     = S_IDLE;
                end
            end
            S_READ:
            begin
                if (issue)
                begin
                    ram_re   = 1'b1;
                    iss_next = iss_reg + CW'(1);
                end
                rd_pend_next = issue || (rd_pend_reg && !load);
                if (load)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    read_byte_next = ram_rdata;
                    last_next      = is_last;
                    used_next      = lvl.used_cnt[FIELD_W-1:0];
                    free_next      = lvl.free_cnt[FIELD_W-1:0];
                    denq_next      = lvl.denq_cnt[FIELD_W-1:0];
                    ddeq_next      = lvl.ddeq_cnt[FIELD_W-1:0];
                    emit_next      = emit_reg + CW'(1);
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= SIZE_W'(CAPACITY);
            front_reg     <= '0;
            rear_reg      <= '0;
            clen_reg      <= '0;
            coff_reg      <= '0;
            crej_reg      <= 1'b0;
            pend_st_reg   <= ST_OK;
            base_reg      <= '0;
            cnt_reg       <= '0;
            iss_reg       <= '0;
            emit_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            read_byte_reg <= '0;
            last_reg      <= 1'b0;
            used_reg      <= '0;
            free_reg      <= '0;
            denq_reg      <= '0;
            ddeq_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            front_reg     <= front_next;
            rear_reg      <= rear_next;
            clen_reg      <= clen_next;
            coff_reg      <= coff_next;
            crej_reg      <= crej_next;
            pend_st_reg   <= pend_st_next;
            base_reg      <= base_next;
            cnt_reg       <= cnt_next;
            iss_reg       <= iss_next;
            emit_reg      <= emit_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            read_byte_reg <= read_byte_next;
            last_reg      <= last_next;
            used_reg      <= used_next;
            free_reg      <= free_next;
            denq_reg      <= denq_next;
            ddeq_reg      <= ddeq_next;
        end
    end

    assign out_valid            = out_valid_reg;
    assign status               = status_reg;
    assign read_byte            = read_byte_reg;
    assign last                 = last_reg;
    assign used_bytes           = used_reg;
    assign free_bytes           = free_reg;
    assign direct_enqueue_bytes = denq_reg;
    assign direct_dequeue_bytes = ddeq_reg;

    a_level_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (lvl.used_cnt + lvl.free_cnt + LVL_W'(1)) == LVL_W'(size_reg))
        else $error("used + free + 1 does not match buffer size");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (SIZE_W'(front_reg) < size_reg) && (SIZE_W'(rear_reg) < size_reg))
        else $error("pointer outside configured size");

    a_chunk_off: assert property (@(posedge clk) disable iff (!rst_n)
        (clen_reg != '0) |-> (coff_reg < clen_reg))
        else $error("chunk offset reached length without commit");

    a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> ((iss_reg <= cnt_reg) && (emit_reg <= iss_reg)))
        else $error("read stream counters out of order");

    a_read_pend: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == S_READ) && (emit_reg != iss_reg))
        else $error("pending read data without an issued read");

endmodule

`default_nettype wire
